>>> rtl/core/indexed_event_min_heap_macros.svh
// ----------------------------------------------------------------------------
// indexed_event_min_heap_macros
// Assertion macros shared by the event heap RTL.
// ----------------------------------------------------------------------------
`ifndef INDEXED_EVENT_MIN_HEAP_MACROS_SVH
`define INDEXED_EVENT_MIN_HEAP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define IEMH_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define IEMH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/iemh_pkg.sv
// ----------------------------------------------------------------------------
// iemh_pkg
// Shared types and constants of the indexed event heap.
// ----------------------------------------------------------------------------
package iemh_pkg;

    localparam int OP_W     = 3;
    localparam int TR_W     = 6;
    localparam int BD_W     = 4;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    localparam int DEF_TRANSITIONS = 64;
    localparam int DEF_BINDINGS    = 16;
    localparam int DEF_KEY_BITS    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT  = 3'd0,
        OP_REPLACE = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_QUERY   = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE = 2'd0,
        ST_DUP  = 2'd1,
        ST_MISS = 2'd2
    } t_status;

endpackage

>>> rtl/core/iemh_if.sv
// ----------------------------------------------------------------------------
// iemh_in_if / iemh_out_if
// Valid/ready channels of the event heap: requests in, results out.
// ----------------------------------------------------------------------------
interface iemh_in_if
    import iemh_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TR_W-1:0]   transition;
    logic [BD_W-1:0]   binding;
    logic [KEY_W-1:0]  key;

    modport source (output valid, operation, transition, binding, key, input ready);
    modport sink   (input valid, operation, transition, binding, key, output ready);
endinterface

interface iemh_out_if
    import iemh_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                was_scheduled;
    logic [COUNT_W-1:0]  count;
    logic                empty_res;
    logic [TR_W-1:0]     top_transition;
    logic [BD_W-1:0]     top_binding;
    logic [KEY_W-1:0]    top_key;

    modport source (output valid, status, was_scheduled, count, empty_res,
                    top_transition, top_binding, top_key, input ready);
    modport sink   (input valid, status, was_scheduled, count, empty_res,
                    top_transition, top_binding, top_key, output ready);
endinterface

>>> rtl/core/indexed_event_min_heap.sv
// ----------------------------------------------------------------------------
// indexed_event_min_heap
// Event scheduler: indexed binary min-heap of (transition, binding) handles.
// ----------------------------------------------------------------------------
// One request is handled at a time. After reset a pass over all 2**(handle
// bits) position entries (1024 by default) clears the position table; no
// request is taken meanwhile. A request without a sift goes through the
// position lookup (S_LOOK), the decode (S_CHK) and the top read (S_TOPR,
// S_TOPD) before the next request can be taken. A sift adds a read and a
// compare for each heap level it moves across, a read and, where a neighbour
// exists, a compare where it stops (in each direction it tries) and one
// write-back. Each level is one read of the heap memory, a compare and a
// write back. A result that has not been taken holds the next request at its
// end. Handles are scheduled when their position entry points below the count
// at a slot holding that handle, so a clear only resets the count.
// ----------------------------------------------------------------------------
module indexed_event_min_heap
    import iemh_pkg::*;
#(
    parameter int TRANSITIONS = DEF_TRANSITIONS,
    parameter int BINDINGS    = DEF_BINDINGS,
    parameter int KEY_BITS    = DEF_KEY_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iemh_in_if.sink    i_in,
    iemh_out_if.source o_out
);

    `include "indexed_event_min_heap_macros.svh"

    localparam int HANDLES = TRANSITIONS * BINDINGS;
    localparam int TW      = (TRANSITIONS > 1) ? $clog2(TRANSITIONS) : 1;
    localparam int BW      = (BINDINGS > 1) ? $clog2(BINDINGS) : 1;
    localparam int HW      = TW + BW;
    localparam int PD      = 1 << HW;
    localparam int SW      = (HANDLES > 1) ? $clog2(HANDLES) : 1;
    localparam int CW      = $clog2(HANDLES + 1);
    localparam int LW      = SW + 1;
    localparam int KB      = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int EW      = HW + KB;

    typedef enum logic [11:0] {
        S_CLR  = 12'b000000000001,
        S_IDLE = 12'b000000000010,
        S_LOOK = 12'b000000000100,
        S_CHK  = 12'b000000001000,
        S_LAST = 12'b000000010000,
        S_UPI  = 12'b000000100000,
        S_UPC  = 12'b000001000000,
        S_DNI  = 12'b000010000000,
        S_DNC  = 12'b000100000000,
        S_FIN  = 12'b001000000000,
        S_TOPR = 12'b010000000000,
        S_TOPD = 12'b100000000000
    } t_state;

    t_state          r_state, n_state;
    logic [HW-1:0]   r_clr, n_clr;
    t_op             r_op, n_op;
    logic [HW-1:0]   r_h, n_h;
    logic            r_hv, n_hv;
    logic [KB-1:0]   r_key, n_key;
    logic [SW-1:0]   r_pos, n_pos;
    logic            r_sched, n_sched;
    t_status         r_status, n_status;
    logic [CW-1:0]   r_count, n_count;
    logic [SW-1:0]   r_cur, n_cur;
    logic [EW-1:0]   r_ent, n_ent;
    logic            r_more, n_more;
    logic            r_moved, n_moved;

    logic            r_ov, n_ov;
    t_status         r_o_status;
    logic            r_o_sched;
    logic [CW-1:0]   r_o_count;
    logic [TW-1:0]   r_o_tr;
    logic [BW-1:0]   r_o_bd;
    logic [KB-1:0]   r_o_key;
    logic            load_out;

    logic            h_we;
    logic [SW-1:0]   h_wa, h_ra, h_rb;
    logic [EW-1:0]   h_wd, h_rd_a, h_rd_b;

    logic [SW-1:0]   r_pos_mem [PD];
    logic            p_we;
    logic [HW-1:0]   p_wa, p_ra;
    logic [SW-1:0]   p_wd, p_rd;

    logic [31:0]     in_tr32, in_bd32, in_key32;
    logic [HW-1:0]   in_h;
    logic            in_hv;
    logic            sched;
    logic [CW-1:0]   last;
    logic [SW-1:0]   parent;
    logic [LW-1:0]   lidx, ridx;
    logic            take_r;
    logic [EW-1:0]   m_ent;
    logic [LW-1:0]   m_idx;

    iemh_heap_ram #(
        .DEPTH (HANDLES),
        .WIDTH (EW)
    ) u_heap (
        .i_clk     (i_clk),
        .i_we      (h_we),
        .i_waddr   (h_wa),
        .i_wdata   (h_wd),
        .i_raddr_a (h_ra),
        .i_raddr_b (h_rb),
        .o_rdata_a (h_rd_a),
        .o_rdata_b (h_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (p_we) begin
            r_pos_mem[p_wa] <= p_wd;
        end
        p_rd <= r_pos_mem[p_ra];
    end

    assign in_tr32  = 32'(i_in.transition);
    assign in_bd32  = 32'(i_in.binding);
    assign in_key32 = i_in.key;
    assign in_h     = {in_tr32[TW-1:0], in_bd32[BW-1:0]};
    assign in_hv    = (in_tr32 < 32'(TRANSITIONS)) && (in_bd32 < 32'(BINDINGS));

    assign sched  = r_hv && (CW'(r_pos) < r_count) && (h_rd_a[EW-1:KB] == r_h);
    assign last   = r_count - CW'(1);
    assign parent = (r_cur - SW'(1)) >> 1;
    assign lidx   = {r_cur, 1'b1};
    assign ridx   = lidx + LW'(1);
    // equal child keys pick the right child
    assign take_r = (ridx < LW'(r_count)) && (h_rd_b[KB-1:0] <= h_rd_a[KB-1:0]);
    assign m_ent  = take_r ? h_rd_b : h_rd_a;
    assign m_idx  = take_r ? ridx : lidx;

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_op     = r_op;
        n_h      = r_h;
        n_hv     = r_hv;
        n_key    = r_key;
        n_pos    = r_pos;
        n_sched  = r_sched;
        n_status = r_status;
        n_count  = r_count;
        n_cur    = r_cur;
        n_ent    = r_ent;
        n_more   = r_more;
        n_moved  = r_moved;
        n_ov     = r_ov && !o_out.ready;
        load_out = 1'b0;
        h_we     = 1'b0;
        h_wa     = r_cur;
        h_wd     = r_ent;
        h_ra     = r_cur;
        h_rb     = r_cur;
        p_we     = 1'b0;
        p_wa     = r_ent[EW-1:KB];
        p_wd     = r_cur;
        p_ra     = r_h;
        i_in.ready = 1'b0;

        unique case (r_state)
            S_CLR: begin
                p_we  = 1'b1;
                p_wa  = r_clr;
                p_wd  = '0;
                n_clr = r_clr + HW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                p_ra       = in_h;
                if (i_in.valid) begin
                    n_op    = t_op'(i_in.operation);
                    n_h     = in_h;
                    n_hv    = in_hv;
                    n_key   = in_key32[KB-1:0];
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                h_ra    = p_rd;
                n_pos   = p_rd;
                n_state = S_CHK;
            end
            S_CHK: begin
                h_ra     = last[SW-1:0];
                n_sched  = sched;
                n_status = ST_DONE;
                n_state  = S_TOPR;
                n_moved  = 1'b0;
                case (r_op)
                    OP_INSERT: begin
                        if (!r_hv) begin
                            n_status = ST_MISS;
                        end else if (sched) begin
                            n_status = ST_DUP;
                        end else if (32'(r_count) < 32'(HANDLES)) begin
                            n_cur   = r_count[SW-1:0];
                            n_ent   = {r_h, r_key};
                            n_count = r_count + CW'(1);
                            n_more  = 1'b0;
                            n_state = S_UPI;
                        end
                    end
                    OP_REPLACE: begin
                        if (!sched) begin
                            n_status = ST_MISS;
                        end else begin
                            n_cur   = r_pos;
                            n_ent   = {r_h, r_key};
                            n_more  = 1'b1;
                            n_state = S_UPI;
                        end
                    end
                    OP_REMOVE: begin
                        if (!sched) begin
                            n_status = ST_MISS;
                        end else begin
                            n_count = last;
                            if (CW'(r_pos) != last) begin
                                n_cur   = r_pos;
                                n_more  = 1'b1;
                                n_state = S_LAST;
                            end
                        end
                    end
                    OP_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_LAST: begin
                n_ent   = h_rd_a;
                n_state = S_DNI;
            end
            S_UPI: begin
                h_ra = parent;
                if (r_cur == '0) begin
                    if (r_more && !r_moved) begin
                        n_more  = 1'b0;
                        n_state = S_DNI;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_UPC;
                end
            end
            S_UPC: begin
                if (r_ent[KB-1:0] < h_rd_a[KB-1:0]) begin
                    h_we    = 1'b1;
                    h_wd    = h_rd_a;
                    p_we    = 1'b1;
                    p_wa    = h_rd_a[EW-1:KB];
                    n_cur   = parent;
                    n_moved = 1'b1;
                    n_state = S_UPI;
                end else if (r_more && !r_moved) begin
                    n_more  = 1'b0;
                    n_state = S_DNI;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DNI: begin
                h_ra = lidx[SW-1:0];
                h_rb = ridx[SW-1:0];
                if (lidx >= LW'(r_count)) begin
                    if (r_more && !r_moved) begin
                        n_more  = 1'b0;
                        n_state = S_UPI;
                    end else begin
                        n_state = S_FIN;
                    end
                end else begin
                    n_state = S_DNC;
                end
            end
            S_DNC: begin
                if (m_ent[KB-1:0] < r_ent[KB-1:0]) begin
                    h_we    = 1'b1;
                    h_wd    = m_ent;
                    p_we    = 1'b1;
                    p_wa    = m_ent[EW-1:KB];
                    n_cur   = m_idx[SW-1:0];
                    n_moved = 1'b1;
                    n_state = S_DNI;
                end else if (r_more && !r_moved) begin
                    n_more  = 1'b0;
                    n_state = S_UPI;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                h_we    = 1'b1;
                p_we    = 1'b1;
                n_state = S_TOPR;
            end
            S_TOPR: begin
                h_ra    = '0;
                n_state = S_TOPD;
            end
            S_TOPD: begin
                h_ra = '0;
                if (!r_ov || o_out.ready) begin
                    load_out = 1'b1;
                    n_ov     = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_clr   <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
            r_more  <= 1'b0;
            r_moved <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_count <= n_count;
            r_ov    <= n_ov;
            r_more  <= n_more;
            r_moved <= n_moved;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_h      <= n_h;
        r_hv     <= n_hv;
        r_key    <= n_key;
        r_pos    <= n_pos;
        r_sched  <= n_sched;
        r_status <= n_status;
        r_cur    <= n_cur;
        r_ent    <= n_ent;
        if (load_out) begin
            r_o_status <= r_status;
            r_o_sched  <= r_sched;
            r_o_count  <= r_count;
            if (r_count == '0) begin
                r_o_tr  <= '0;
                r_o_bd  <= '0;
                r_o_key <= '0;
            end else begin
                r_o_tr  <= h_rd_a[EW-1:EW-TW];
                r_o_bd  <= h_rd_a[KB+BW-1:KB];
                r_o_key <= h_rd_a[KB-1:0];
            end
        end
    end

    logic [31:0] o_cnt32, o_tr32, o_bd32, o_key32;
    assign o_cnt32 = 32'(r_o_count);
    assign o_tr32  = 32'(r_o_tr);
    assign o_bd32  = 32'(r_o_bd);
    assign o_key32 = 32'(r_o_key);

    assign o_out.valid          = r_ov;
    assign o_out.status         = r_o_status;
    assign o_out.was_scheduled  = r_o_sched;
    assign o_out.count          = o_cnt32[COUNT_W-1:0];
    assign o_out.empty_res      = (r_o_count == '0);
    assign o_out.top_transition = o_tr32[TR_W-1:0];
    assign o_out.top_binding    = o_bd32[BD_W-1:0];
    assign o_out.top_key        = o_key32[KEY_W-1:0];

    `IEMH_ASSERT_NEXT(a_count_only_in_check, r_state != S_CHK, $stable(r_count),
        "heap count changed outside request decode")
    `IEMH_ASSERT_SAME(a_cur_below_count,
        r_state == S_UPC || r_state == S_DNC || r_state == S_FIN,
        CW'(r_cur) < r_count, "sift position beyond heap count")
    `IEMH_ASSERT_SAME(a_no_accept_in_clear, r_state == S_CLR, !i_in.ready,
        "request accepted during position table clear")

endmodule

>>> rtl/core/iemh_heap_ram.sv
// ----------------------------------------------------------------------------
// iemh_heap_ram
// Heap slot memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module iemh_heap_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 42,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> sim/tb_heap_scoreboard.sv
// ----------------------------------------------------------------------------
// tb_heap_scoreboard
// Expected-result store and predictor of the indexed event heap. It keeps its
// own heap, position table and keys, and checks each result field by field.
// ----------------------------------------------------------------------------
package tb_heap_scoreboard_pkg;
    import iemh_pkg::*;

    localparam int NHANDLE = DEF_TRANSITIONS * DEF_BINDINGS;
    localparam int UNSCHED = -1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                was_scheduled;
        logic [COUNT_W-1:0]  count;
        logic                empty_res;
        logic [TR_W-1:0]     top_transition;
        logic [BD_W-1:0]     top_binding;
        logic [KEY_W-1:0]    top_key;
    } t_heap_result;

    class heap_scoreboard;
        int             slot_of[NHANDLE];
        int             handle_at[NHANDLE];
        logic [KEY_W-1:0] key_of[NHANDLE];
        int             fill;
        t_heap_result   pending[$];
        int             errors;

        function new();
            foreach (slot_of[i]) slot_of[i] = UNSCHED;
            foreach (handle_at[i]) handle_at[i] = 0;
            fill = 0;
            errors = 0;
        endfunction

        function logic [KEY_W-1:0] key_at(int p);
            return key_of[handle_at[p]];
        endfunction

        function void swap(int a, int b);
            int ha;
            int hb;
            ha = handle_at[a];
            hb = handle_at[b];
            slot_of[ha] = b;
            slot_of[hb] = a;
            handle_at[a] = hb;
            handle_at[b] = ha;
        endfunction

        function void bubble_up(int p);
            int par;
            while (p > 0) begin
                par = (p - 1) / 2;
                if (key_at(p) < key_at(par)) begin
                    swap(p, par);
                    p = par;
                end else begin
                    break;
                end
            end
        endfunction

        function void bubble_down(int p);
            int l;
            int m;
            forever begin
                l = 2 * p + 1;
                if (l >= fill) break;
                if (l + 1 >= fill) m = l;
                else m = (key_at(l) < key_at(l + 1)) ? l : l + 1;
                if (key_at(m) < key_at(p)) begin
                    swap(m, p);
                    p = m;
                end else begin
                    break;
                end
            end
        endfunction

        function bit is_scheduled(logic [TR_W-1:0] tr, logic [BD_W-1:0] bd);
            return slot_of[tr * DEF_BINDINGS + bd] != UNSCHED;
        endfunction

        function int count_now();
            return fill;
        endfunction

        // predict one accepted request
        function void note_request(logic [OP_W-1:0] op, logic [TR_W-1:0] tr,
                                   logic [BD_W-1:0] bd, logic [KEY_W-1:0] k);
            int h;
            int s;
            int last;
            bit sched;
            t_heap_result r;
            h = tr * DEF_BINDINGS + bd;
            sched = slot_of[h] != UNSCHED;
            r = '0;
            r.status = ST_DONE;
            case (op)
                OP_INSERT: begin
                    if (sched) r.status = ST_DUP;
                    else if (fill < NHANDLE) begin
                        key_of[h] = k;
                        slot_of[h] = fill;
                        handle_at[fill] = h;
                        fill++;
                        bubble_up(fill - 1);
                    end
                end
                OP_REPLACE: begin
                    if (!sched) r.status = ST_MISS;
                    else begin
                        s = slot_of[h];
                        key_of[h] = k;
                        bubble_up(s);
                        bubble_down(s);
                    end
                end
                OP_REMOVE: begin
                    if (!sched) r.status = ST_MISS;
                    else begin
                        s = slot_of[h];
                        last = fill - 1;
                        slot_of[h] = UNSCHED;
                        fill = last;
                        if (s != last) begin
                            handle_at[s] = handle_at[last];
                            slot_of[handle_at[s]] = s;
                            bubble_down(s);
                            bubble_up(s);
                        end
                    end
                end
                OP_CLEAR: begin
                    foreach (slot_of[i]) slot_of[i] = UNSCHED;
                    fill = 0;
                end
                default: ;
            endcase
            r.was_scheduled = sched;
            r.count = COUNT_W'(fill);
            r.empty_res = fill == 0;
            if (fill > 0) begin
                r.top_transition = TR_W'(handle_at[0] / DEF_BINDINGS);
                r.top_binding = BD_W'(handle_at[0] % DEF_BINDINGS);
                r.top_key = key_of[handle_at[0]];
            end
            pending = {pending, r};
        endfunction

        function void check_result(t_heap_result got);
            t_heap_result e;
            if (pending.size() == 0) begin
                $error("result with nothing pending");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
            if (got.was_scheduled !== e.was_scheduled) begin
                $error("was_scheduled exp %0d got %0d", e.was_scheduled,
                       got.was_scheduled); errors++;
            end
            if (got.count !== e.count) begin
                $error("count exp %0d got %0d", e.count, got.count); errors++;
            end
            if (got.empty_res !== e.empty_res) begin
                $error("empty_res exp %0d got %0d", e.empty_res, got.empty_res);
                errors++;
            end
            if (got.top_transition !== e.top_transition) begin
                $error("top_transition exp %0d got %0d", e.top_transition,
                       got.top_transition); errors++;
            end
            if (got.top_binding !== e.top_binding) begin
                $error("top_binding exp %0d got %0d", e.top_binding,
                       got.top_binding); errors++;
            end
            if (got.top_key !== e.top_key) begin
                $error("top_key exp %h got %h", e.top_key, got.top_key); errors++;
            end
        endfunction
    endclass
endpackage

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives random and directed heap requests through the valid/ready channels
// with random idling on both sides, and checks every result against the
// scoreboard's own heap.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import iemh_pkg::*;
    import tb_heap_scoreboard_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_cycles = 0;

    iemh_in_if  req_ch ();
    iemh_out_if res_ch ();

    indexed_event_min_heap dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch.sink),
        .o_out   (res_ch.source)
    );

    heap_scoreboard heap_sb = new();

    always #4 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.operation = OP_QUERY;
        req_ch.transition = '0;
        req_ch.binding = '0;
        req_ch.key = '0;
        res_ch.ready = 1'b0;
    end

    // result side: stall at random, plus long hold-offs
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            heap_sb.check_result({res_ch.status, res_ch.was_scheduled, res_ch.count,
                                  res_ch.empty_res, res_ch.top_transition,
                                  res_ch.top_binding, res_ch.top_key});
        end
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            heap_sb.note_request(req_ch.operation, req_ch.transition,
                                 req_ch.binding, req_ch.key);
        end
    end

    task automatic send_request(logic [OP_W-1:0] op, logic [TR_W-1:0] tr,
                                logic [BD_W-1:0] bd, logic [KEY_W-1:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.transition <= tr;
        req_ch.binding <= bd;
        req_ch.key <= k;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(3))
            0: return $urandom_range(7);
            1: return '1 - $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    // mostly insert/replace/remove of a small handle pool, some noise
    task automatic send_random();
        int op_pick;
        logic [TR_W-1:0] tr;
        logic [BD_W-1:0] bd;
        op_pick = $urandom_range(99);
        tr = ($urandom_range(3) == 0) ? TR_W'($urandom) : TR_W'($urandom_range(5));
        bd = BD_W'($urandom);
        if (heap_sb.count_now() < 40 && op_pick < 45)
            send_request(OP_INSERT, tr, bd, rand_key());
        else if (op_pick < 35)
            send_request(OP_INSERT, tr, bd, rand_key());
        else if (op_pick < 65)
            send_request(OP_REPLACE, tr, bd, rand_key());
        else if (op_pick < 95)
            send_request(OP_REMOVE, tr, bd, rand_key());
        else if (op_pick < 97)
            send_request(OP_CLEAR, tr, bd, $urandom);
        else
            send_request(3'($urandom_range(4, 7)), tr, bd, $urandom);
    endtask

    initial begin
        int n;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: extremes, duplicates, misses, ties, unused codes
        send_request(OP_QUERY, 0, 0, 0);
        send_request(OP_REMOVE, 0, 0, 0);
        send_request(OP_REPLACE, 63, 15, 5);
        send_request(OP_INSERT, 63, 15, '1);
        send_request(OP_INSERT, 0, 0, '1);
        send_request(OP_INSERT, 0, 0, 3);
        send_request(OP_INSERT, 1, 2, 0);
        send_request(OP_INSERT, 2, 5, 0);
        send_request(OP_INSERT, 42, 10, 32'h5555_5555);
        send_request(OP_INSERT, 21, 5, 32'hAAAA_AAAA);
        send_request(OP_REPLACE, 63, 15, 0);
        send_request(OP_REPLACE, 1, 2, '1);
        send_request(OP_REMOVE, 63, 15, 0);
        send_request(OP_REMOVE, 0, 0, 0);
        send_request(OP_QUERY, 2, 5, 0);
        send_request(3'd5, 1, 2, 0);
        send_request(3'd6, 3, 3, 0);
        send_request(3'd7, 42, 10, 0);
        send_request(OP_CLEAR, 21, 5, 0);
        send_request(OP_REMOVE, 21, 5, 0);
        send_request(OP_QUERY, 0, 0, 0);
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 56; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 56; end
                3: begin send_idle_pct = 16; recv_stall_pct = 16; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (ph == 4) hold_cycles = 400;
            n = (ph == 4) ? 70 : 120;
            repeat (n) send_random();
        end
        req_ch.valid <= 1'b0;
        while (heap_sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (heap_sb.errors == 0 && heap_sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
